@@ hw/rtl/skvt_pkg.sv @@
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared sizes, codes and the entry layout of the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int CAPACITY    = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int KEY_W       = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int ENTRY_W     = KEY_W + VALUE_WIDTH;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_DUP       = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [VALUE_WIDTH-1:0] value;
  } entry_t;

endpackage

@@ hw/rtl/skvt_ram.sv @@
// ----------------------------------------------------------------------------
// skvt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/sorted_key_value_table.sv @@
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Map of signed keys to values held in one RAM, sorted by key. Binary search
// finds the slot; inserts and deletes move later entries one slot per cycle.
// ----------------------------------------------------------------------------
//  channel  ports                                        handshake
//  input    in_kind, in_key, in_value                    start && !busy
//  result   out_status, out_value_out, out_entry_count   out_valid (1 cycle)
//
//  Search: each probe is a RAM read (S_PROBE), then a compare (S_CMP), at most
//  9 probes, and then the candidate slot is read and checked (S_CHECK).
//  Insert/delete then stream the tail through the RAM port, one entry per
//  cycle. An unused kind is answered from idle with NOT_FOUND, with no search.
//  Reset empties the table at once (fill count only, no clearing pass). busy is
//  high from accept until the result beat, bar unused kinds; receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_key_value_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_kind,
  input  logic signed [skvt_pkg::KEY_W-1:0] in_key,
  input  logic [skvt_pkg::VALUE_WIDTH-1:0]  in_value,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [skvt_pkg::VALUE_WIDTH-1:0]  out_value_out,
  output logic [skvt_pkg::CNT_W-1:0]        out_entry_count
);

  import skvt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_CHECK,
    S_SHUP,
    S_SHDN
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [CNT_W-1:0]       lo_r, lo_nxt;
  logic [CNT_W-1:0]       hi_r, hi_nxt;
  logic [CNT_W-1:0]       mid_r, mid_nxt;
  logic [CNT_W-1:0]       j_r, j_nxt;
  logic [CNT_W-1:0]       wa_r, wa_nxt;
  logic                   pend_r, pend_nxt;
  kind_t                  kind_r, kind_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                   ov_r, ov_nxt;
  status_t                os_r, os_nxt;
  logic [VALUE_WIDTH-1:0] ovv_r, ovv_nxt;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_wa;
  entry_t                 ram_wd;
  logic [IDX_W-1:0]       ram_ra;
  entry_t                 ram_rd;
  logic [ENTRY_W-1:0]     ram_rd_raw;
  logic [CNT_W-1:0]       mid;
  logic                   hit;
  logic                   key_less;

  skvt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd_raw)
  );

  assign ram_rd   = entry_t'(ram_rd_raw);
  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign key_less = $signed(ram_rd.key) < $signed(key_r);
  assign hit      = (lo_r < fill_r) && (ram_rd.key == key_r);

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    j_nxt     = j_r;
    wa_nxt    = wa_r;
    pend_nxt  = pend_r;
    kind_nxt  = kind_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    ov_nxt    = 1'b0;
    os_nxt    = os_r;
    ovv_nxt   = ovv_r;
    ram_we    = 1'b0;
    ram_wa    = wa_r[IDX_W-1:0];
    ram_wd    = ram_rd;
    ram_ra    = mid[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt = kind_t'(in_kind);
          key_nxt  = in_key;
          val_nxt  = in_value;
          lo_nxt   = '0;
          hi_nxt   = fill_r;
          if (kind_t'(in_kind) == KIND_UNUSED) begin
            ov_nxt  = 1'b1;
            os_nxt  = ST_NOT_FOUND;
            ovv_nxt = '0;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        if (lo_r < hi_r) begin
          ram_ra    = mid[IDX_W-1:0];
          mid_nxt   = mid;
          state_nxt = S_CMP;
        end else begin
          // lo may equal the capacity here; hit masks the stale read
          ram_ra    = lo_r[IDX_W-1:0];
          state_nxt = S_CHECK;
        end
      end

      S_CMP: begin
        if (key_less) begin
          lo_nxt = mid_r + CNT_W'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_PROBE;
      end

      S_CHECK: begin
        state_nxt = S_IDLE;
        ovv_nxt   = '0;
        unique case (kind_r)
          KIND_INSERT: begin
            if (hit) begin
              ov_nxt = 1'b1;
              os_nxt = ST_DUP;
            end else if (fill_r >= CAP_CNT) begin
              ov_nxt = 1'b1;
              os_nxt = ST_FULL;
            end else begin
              j_nxt     = fill_r;
              pend_nxt  = 1'b0;
              state_nxt = S_SHUP;
            end
          end
          KIND_LOOKUP: begin
            ov_nxt = 1'b1;
            if (hit) begin
              os_nxt  = ST_OK;
              ovv_nxt = ram_rd.value;
            end else begin
              os_nxt = ST_NOT_FOUND;
            end
          end
          KIND_DELETE: begin
            if (hit) begin
              val_nxt   = ram_rd.value;
              j_nxt     = lo_r + CNT_W'(1);
              pend_nxt  = 1'b0;
              state_nxt = S_SHDN;
            end else begin
              ov_nxt = 1'b1;
              os_nxt = ST_NOT_FOUND;
            end
          end
          default: begin
            ov_nxt = 1'b1;
            os_nxt = ST_NOT_FOUND;
          end
        endcase
      end

      S_SHUP: begin
        // read slot j-1 while the previous beat's entry lands one slot up
        ram_we = pend_r;
        ram_ra = IDX_W'(j_r - CNT_W'(1));
        if (j_r > lo_r) begin
          wa_nxt   = j_r;
          pend_nxt = 1'b1;
          j_nxt    = j_r - CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            ram_we       = 1'b1;
            ram_wa       = lo_r[IDX_W-1:0];
            ram_wd.key   = key_r;
            ram_wd.value = val_r;
            fill_nxt     = fill_r + CNT_W'(1);
            ov_nxt       = 1'b1;
            os_nxt       = ST_OK;
            ovv_nxt      = '0;
            state_nxt    = S_IDLE;
          end
        end
      end

      S_SHDN: begin
        ram_we = pend_r;
        ram_ra = j_r[IDX_W-1:0];
        if (j_r < fill_r) begin
          wa_nxt   = j_r - CNT_W'(1);
          pend_nxt = 1'b1;
          j_nxt    = j_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            fill_nxt  = fill_r - CNT_W'(1);
            ov_nxt    = 1'b1;
            os_nxt    = ST_OK;
            ovv_nxt   = val_r;
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
    end
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    j_r    <= j_nxt;
    wa_r   <= wa_nxt;
    kind_r <= kind_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    os_r   <= os_nxt;
    ovv_r  <= ovv_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_value_out   = ovv_r;
  assign out_entry_count = fill_r;

endmodule

@@ test/sorted_key_value_table_test.sv @@
// ----------------------------------------------------------------------------
// sorted_key_value_table_test
// Drives insert, lookup and delete requests into the sorted key/value table
// and checks every result beat against a local copy of the map, or a fixed
// result for typed rows: a short directed walk over empty-table, extreme-key,
// duplicate and missing-key cases; random filling to capacity; drain-heavy traffic.
// ----------------------------------------------------------------------------
module sorted_key_value_table_test;
  import skvt_pkg::*;

  typedef struct packed {
    kind_t                  kind;
    logic [KEY_W-1:0]       key;
    logic [VALUE_WIDTH-1:0] value;
  } table_request_t;

  typedef struct packed {
    status_t                status;
    logic [VALUE_WIDTH-1:0] value_out;
    logic [CNT_W-1:0]       entry_count;
  } table_result_t;

  typedef struct packed {
    table_request_t req;
    logic           typed;
    table_result_t  res;
  } directed_row_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              in_kind = KIND_LOOKUP;
  logic signed [KEY_W-1:0] in_key = '0;
  logic [VALUE_WIDTH-1:0]  in_value = '0;
  logic                    out_valid;
  logic [1:0]              out_status;
  logic [VALUE_WIDTH-1:0]  out_value_out;
  logic [CNT_W-1:0]        out_entry_count;

  // local copy of the map
  logic signed [KEY_W-1:0] key_store [CAPACITY];
  logic [VALUE_WIDTH-1:0]  value_store [CAPACITY];
  int                      entries_held = 0;

  table_result_t pending_results[$];
  directed_row_t directed_rows[$];
  int            mismatch_count = 0;

  sorted_key_value_table u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_value_out   (out_value_out),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Applies one request to the local map and returns the result it yields.
  function automatic table_result_t apply_request(table_request_t req);
    table_result_t           r;
    logic signed [KEY_W-1:0] key;
    int                      pos;
    bit                      hit;
    key = req.key;
    r.status = ST_NOT_FOUND;
    r.value_out = '0;
    pos = 0;
    while (pos < entries_held && key_store[pos] < key) pos++;
    hit = (pos < entries_held) && (key_store[pos] == key);
    case (req.kind)
      KIND_INSERT: begin
        if (hit) begin
          r.status = ST_DUP;
        end else if (entries_held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = entries_held; i > pos; i--) begin
            key_store[i] = key_store[i-1];
            value_store[i] = value_store[i-1];
          end
          key_store[pos] = key;
          value_store[pos] = req.value;
          entries_held++;
          r.status = ST_OK;
        end
      end
      KIND_LOOKUP: begin
        if (hit) begin
          r.status = ST_OK;
          r.value_out = value_store[pos];
        end
      end
      KIND_DELETE: begin
        if (hit) begin
          r.status = ST_OK;
          r.value_out = value_store[pos];
          for (int i = pos; i + 1 < entries_held; i++) begin
            key_store[i] = key_store[i+1];
            value_store[i] = value_store[i+1];
          end
          entries_held--;
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(entries_held);
    return r;
  endfunction

  // Keys favor entries already held so lookups and deletes hit, with some
  // extremes and fully random keys mixed in.
  function automatic table_request_t random_request(int insert_pct, int lookup_pct,
                                                    int delete_pct);
    table_request_t r;
    int             roll;
    int             hit_pct;
    roll = $urandom_range(99);
    if (roll < insert_pct) r.kind = KIND_INSERT;
    else if (roll < insert_pct + lookup_pct) r.kind = KIND_LOOKUP;
    else if (roll < insert_pct + lookup_pct + delete_pct) r.kind = KIND_DELETE;
    else r.kind = KIND_UNUSED;
    hit_pct = (r.kind == KIND_INSERT) ? 15 : 70;
    case ($urandom_range(15))
      0: r.key = 32'h8000_0000;
      1: r.key = 32'h7FFF_FFFF;
      2: r.key = 32'h0000_0000;
      3: r.key = 32'hFFFF_FFFF;
      default: begin
        if (entries_held > 0 && $urandom_range(99) < hit_pct)
          r.key = key_store[$urandom_range(entries_held - 1)];
        else
          r.key = $urandom;
      end
    endcase
    r.value = $urandom;
    return r;
  endfunction

  task automatic add_row(kind_t kind, logic [KEY_W-1:0] key, logic [VALUE_WIDTH-1:0] value,
                         logic typed, status_t status, logic [VALUE_WIDTH-1:0] value_out,
                         int count);
    directed_row_t row;
    row.req = '{kind: kind, key: key, value: value};
    row.typed = typed;
    row.res = '{status: status, value_out: value_out, entry_count: CNT_W'(count)};
    directed_rows.push_back(row);
  endtask

  // Presents one request after an optional gap and holds it until accepted.
  task automatic send_request(table_request_t req, logic typed, table_result_t typed_res,
                              int idle_pct);
    table_result_t r;
    int            gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (idle_pct > 0 && $urandom_range(7) == 0) gap += $urandom_range(300, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= req.kind;
    in_key <= req.key;
    in_value <= req.value;
    do @(posedge clk); while (busy);
    r = apply_request(req);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  initial begin
    int guard;
    add_row(KIND_LOOKUP, 32'h0000_0000, 32'h0, 1'b1, ST_NOT_FOUND, 32'h0, 0);
    add_row(KIND_DELETE, 32'h0000_0000, 32'h0, 1'b1, ST_NOT_FOUND, 32'h0, 0);
    add_row(KIND_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, ST_OK, 32'h0, 1);
    add_row(KIND_INSERT, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, ST_OK, 32'h0, 2);
    add_row(KIND_INSERT, 32'h0000_0000, 32'hA5A5_A5A5, 1'b1, ST_OK, 32'h0, 3);
    add_row(KIND_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 1'b1, ST_OK, 32'h0, 4);
    add_row(KIND_INSERT, 32'h0000_0000, 32'h0000_0001, 1'b1, ST_DUP, 32'h0, 4);
    add_row(KIND_LOOKUP, 32'h8000_0000, 32'h0, 1'b1, ST_OK, 32'hFFFF_FFFF, 4);
    add_row(KIND_LOOKUP, 32'h7FFF_FFFF, 32'h0, 1'b1, ST_OK, 32'h0000_0000, 4);
    add_row(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK, 32'h5A5A_5A5A, 4);
    add_row(KIND_LOOKUP, 32'h0000_0001, 32'h0, 1'b1, ST_NOT_FOUND, 32'h0, 4);
    add_row(KIND_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 32'h0, 4);
    add_row(KIND_DELETE, 32'hFFFF_FFFF, 32'h0, 1'b1, ST_OK, 32'h5A5A_5A5A, 3);
    add_row(KIND_DELETE, 32'hFFFF_FFFF, 32'h0, 1'b1, ST_NOT_FOUND, 32'h0, 3);
    add_row(KIND_LOOKUP, 32'h0000_0000, 32'h0, 1'b1, ST_OK, 32'hA5A5_A5A5, 3);
    add_row(KIND_DELETE, 32'h8000_0000, 32'h0, 1'b1, ST_OK, 32'hFFFF_FFFF, 2);
    add_row(KIND_DELETE, 32'h7FFF_FFFF, 32'h0, 1'b1, ST_OK, 32'h0000_0000, 1);
    add_row(KIND_DELETE, 32'h0000_0000, 32'h0, 1'b1, ST_OK, 32'hA5A5_A5A5, 0);
    add_row(KIND_INSERT, 32'h0000_0001, 32'h1234_5678, 1'b0, ST_OK, 32'h0, 0);
    add_row(KIND_INSERT, 32'hFFFF_FFFE, 32'h8765_4321, 1'b0, ST_OK, 32'h0, 0);
    add_row(KIND_LOOKUP, 32'h0000_0001, 32'h0, 1'b0, ST_OK, 32'h0, 0);
    add_row(KIND_DELETE, 32'hFFFF_FFFE, 32'h0, 1'b0, ST_OK, 32'h0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res, 0);

    // mixed traffic, no idling
    repeat (80) send_request(random_request(45, 25, 22), 1'b0, '0, 0);

    // fill to capacity, then hammer the full table
    guard = 0;
    while (entries_held < CAPACITY && guard < 600) begin
      send_request(random_request(96, 2, 1), 1'b0, '0, 52);
      guard++;
    end
    repeat (50) send_request(random_request(50, 25, 20), 1'b0, '0, 52);

    // drain-heavy traffic with light idling
    repeat (100) send_request(random_request(15, 25, 55), 1'b0, '0, 15);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin : check_results
    table_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_status);
          mismatch_count++;
        end
        if (out_value_out !== exp_res.value_out) begin
          $error("value_out: expected %h, got %h", exp_res.value_out, out_value_out);
          mismatch_count++;
        end
        if (out_entry_count !== exp_res.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_res.entry_count, out_entry_count);
          mismatch_count++;
        end
      end
    end
  end

endmodule
